// ----- rtl/assert_macros.svh -----
// Assertion macros used by the top level of the RIFF/WAVE stream parser.
// Each macro expects signals named clk and arst_n in the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed in the same cycle");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed in the following cycle");

`endif

// ----- rtl/rwsp_pkg.sv -----
// Shared types and constants for the RIFF/WAVE stream parser.
// Used by the parser core, the output buffer and the top level.
package rwsp_pkg;

	localparam int unsigned TDATA_W = 216;

	localparam logic [1:0] KIND_REPORT = 2'd0;
	localparam logic [1:0] KIND_PCM    = 2'd1;
	localparam logic [1:0] KIND_DONE   = 2'd2;

	localparam logic [1:0] ST_OK          = 2'd0;
	localparam logic [1:0] ST_EARLY_END   = 2'd1;
	localparam logic [1:0] ST_FORMAT_ERR  = 2'd2;
	localparam logic [1:0] ST_UNSUPPORTED = 2'd3;

	localparam logic [31:0] ID_RIFF = 32'h4646_4952;
	localparam logic [31:0] ID_WAVE = 32'h4556_4157;
	localparam logic [31:0] ID_FMT  = 32'h2074_6D66;
	localparam logic [31:0] ID_DATA = 32'h6174_6164;

	localparam logic [31:0] FMT_CORE_BYTES = 32'd16;
	localparam logic [15:0] PCM_FORMAT     = 16'd1;
	localparam logic [15:0] PCM_CHANNELS   = 16'd2;
	localparam logic [15:0] PCM_BITS       = 16'd16;
	localparam logic [15:0] PCM_ALIGN      = 16'd4;
	localparam logic [31:0] PCM_RATE       = 32'd44100;

	typedef struct packed {
		logic [1:0]  kind;
		logic [1:0]  status;
		logic [15:0] fmt_code;
		logic [15:0] channels;
		logic [31:0] smp_rate;
		logic [31:0] bytes_per_sec;
		logic [15:0] frame_bytes;
		logic [15:0] smp_bits;
		logic [31:0] pcm_len;
		logic [31:0] pcm_start;
		logic [15:0] pcm_word;
		logic        last;
	} result_t;

endpackage

// ----- rtl/rwsp_core.sv -----
// Parser core of the RIFF/WAVE stream parser: header check, chunk walk,
// fmt capture and PCM word assembly. Depends on rwsp_pkg.
module rwsp_core import rwsp_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_take,
	input  logic [7:0] in_byte,
	input  logic    in_end,
	output logic    res_valid,
	output result_t res
);

	typedef enum logic [2:0] {
		PH_HEADER,
		PH_CHUNK,
		PH_FMT,
		PH_SKIP,
		PH_PCM,
		PH_IDLE
	} phase_t;

	phase_t      phase_q, phase_d;
	logic [3:0]  idx_q, idx_d;
	logic [63:0] gather_q, gather_d;
	logic [32:0] skip_q, skip_d;
	logic        fmt_seen_q, fmt_seen_d;
	logic [63:0] fmt_q, fmt_d;
	logic [63:0] rate_q, rate_d;
	logic [31:0] data_left_q, data_left_d;
	logic [31:0] pos_q, pos_d;
	logic [7:0]  low_hold_q, low_hold_d;
	logic        low_valid_q, low_valid_d;
	logic        riff_bad_q, riff_bad_d;

	logic [63:0] gath_new;
	logic [31:0] chunk_id;
	logic [31:0] chk_len;
	logic [31:0] dl_dec;
	logic        supported;

	function automatic result_t make_report(input logic [1:0] st, input logic [63:0] ff,
			input logic [63:0] rf, input logic [31:0] size, input logic [31:0] offs,
			input logic lst);
		result_t r;
		r = '0;
		r.kind          = KIND_REPORT;
		r.status        = st;
		r.fmt_code      = ff[15:0];
		r.channels      = ff[31:16];
		r.smp_rate      = ff[63:32];
		r.bytes_per_sec = rf[31:0];
		r.frame_bytes   = rf[47:32];
		r.smp_bits      = rf[63:48];
		r.pcm_len       = size;
		r.pcm_start     = offs;
		r.last          = lst;
		return r;
	endfunction

	assign gath_new   = {in_byte, gather_q[63:8]};
	assign chunk_id   = gath_new[31:0];
	assign chk_len    = gath_new[63:32];
	assign dl_dec     = data_left_q - 32'd1;
	assign supported  = (fmt_q[15:0] == PCM_FORMAT) && (fmt_q[31:16] == PCM_CHANNELS) &&
		(rate_q[63:48] == PCM_BITS) && (fmt_q[63:32] == PCM_RATE) &&
		(rate_q[47:32] == PCM_ALIGN);

	always_comb begin
		phase_d     = phase_q;
		idx_d       = idx_q;
		gather_d    = gather_q;
		skip_d      = skip_q;
		fmt_seen_d  = fmt_seen_q;
		fmt_d       = fmt_q;
		rate_d      = rate_q;
		data_left_d = data_left_q;
		pos_d       = pos_q;
		low_hold_d  = low_hold_q;
		low_valid_d = low_valid_q;
		riff_bad_d  = riff_bad_q;
		res_valid   = 1'b0;
		res         = '0;

		if (in_take && in_end) begin
			if (phase_q == PH_HEADER || phase_q == PH_CHUNK || phase_q == PH_FMT ||
					phase_q == PH_SKIP) begin
				res_valid = 1'b1;
				res = make_report(ST_EARLY_END, fmt_q, rate_q, 32'd0, 32'd0, 1'b1);
			end else if (phase_q == PH_PCM) begin
				res_valid = 1'b1;
				res.kind  = KIND_DONE;
				res.last  = 1'b1;
			end
			phase_d     = PH_HEADER;
			idx_d       = '0;
			gather_d    = '0;
			skip_d      = '0;
			fmt_seen_d  = 1'b0;
			fmt_d       = '0;
			rate_d      = '0;
			data_left_d = '0;
			pos_d       = '0;
			low_hold_d  = '0;
			low_valid_d = 1'b0;
			riff_bad_d  = 1'b0;
		end else if (in_take) begin
			pos_d    = pos_q + 32'd1;
			gather_d = gath_new;
			case (phase_q)
				PH_HEADER: begin
					if (idx_q == 4'd3)
						riff_bad_d = (gath_new[63:32] != ID_RIFF);
					if (idx_q >= 4'd11) begin
						if (riff_bad_q || gath_new[63:32] != ID_WAVE) begin
							res_valid = 1'b1;
							res = make_report(ST_FORMAT_ERR, fmt_q, rate_q, 32'd0, 32'd0, 1'b1);
							phase_d = PH_IDLE;
						end else begin
							phase_d = PH_CHUNK;
							idx_d   = '0;
						end
					end else begin
						idx_d = idx_q + 4'd1;
					end
				end
				PH_CHUNK: begin
					if (idx_q >= 4'd7) begin
						if (chunk_id == ID_FMT) begin
							if (chk_len < FMT_CORE_BYTES) begin
								res_valid = 1'b1;
								res = make_report(ST_FORMAT_ERR, fmt_q, rate_q, 32'd0, 32'd0,
									1'b1);
								phase_d = PH_IDLE;
							end else begin
								// Bytes past the 16-byte core plus the pad byte of an odd size.
								skip_d  = {1'b0, chk_len} - {1'b0, FMT_CORE_BYTES} +
									{32'd0, chk_len[0]};
								phase_d = PH_FMT;
								idx_d   = '0;
							end
						end else if (chunk_id == ID_DATA) begin
							res_valid = 1'b1;
							phase_d   = PH_IDLE;
							if (!fmt_seen_q) begin
								res = make_report(ST_FORMAT_ERR, fmt_q, rate_q, 32'd0, 32'd0,
									1'b1);
							end else if (!supported) begin
								res = make_report(ST_UNSUPPORTED, fmt_q, rate_q, chk_len,
									pos_d, 1'b1);
							end else begin
								res = make_report(ST_OK, fmt_q, rate_q, chk_len, pos_d,
									chk_len < 32'd2);
								data_left_d = chk_len;
								low_valid_d = 1'b0;
								if (chk_len >= 32'd2)
									phase_d = PH_PCM;
							end
						end else begin
							skip_d = {1'b0, chk_len} + {32'd0, chk_len[0]};
							if (chk_len == 32'd0) begin
								phase_d = PH_CHUNK;
								idx_d   = '0;
							end else begin
								phase_d = PH_SKIP;
							end
						end
					end else begin
						idx_d = idx_q + 4'd1;
					end
				end
				PH_FMT: begin
					if (idx_q == 4'd7)
						fmt_d = gath_new;
					if (idx_q >= 4'd15) begin
						rate_d     = gath_new;
						fmt_seen_d = 1'b1;
						if (skip_q == '0) begin
							phase_d = PH_CHUNK;
							idx_d   = '0;
						end else begin
							phase_d = PH_SKIP;
						end
					end else begin
						idx_d = idx_q + 4'd1;
					end
				end
				PH_SKIP: begin
					if (skip_q <= 33'd1) begin
						skip_d  = '0;
						phase_d = PH_CHUNK;
						idx_d   = '0;
					end else begin
						skip_d = skip_q - 33'd1;
					end
				end
				PH_PCM: begin
					data_left_d = dl_dec;
					if (low_valid_q) begin
						res_valid    = 1'b1;
						res.kind     = KIND_PCM;
						res.pcm_word = {in_byte, low_hold_q};
						res.last     = (dl_dec < 32'd2);
						low_valid_d  = 1'b0;
						if (dl_dec < 32'd2)
							phase_d = PH_IDLE;
					end else begin
						low_hold_d  = in_byte;
						low_valid_d = 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HEADER;
			idx_q       <= '0;
			gather_q    <= '0;
			skip_q      <= '0;
			fmt_seen_q  <= 1'b0;
			fmt_q       <= '0;
			rate_q      <= '0;
			data_left_q <= '0;
			pos_q       <= '0;
			low_hold_q  <= '0;
			low_valid_q <= 1'b0;
			riff_bad_q  <= 1'b0;
		end else begin
			phase_q     <= phase_d;
			idx_q       <= idx_d;
			gather_q    <= gather_d;
			skip_q      <= skip_d;
			fmt_seen_q  <= fmt_seen_d;
			fmt_q       <= fmt_d;
			rate_q      <= rate_d;
			data_left_q <= data_left_d;
			pos_q       <= pos_d;
			low_hold_q  <= low_hold_d;
			low_valid_q <= low_valid_d;
			riff_bad_q  <= riff_bad_d;
		end
	end

endmodule

// ----- rtl/rwsp_out_buf.sv -----
// Output register with a skid stage for the RIFF/WAVE stream parser.
// Holds up to two results so the input side keeps full rate while the output is ready. Depends on rwsp_pkg.
module rwsp_out_buf import rwsp_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  result_t push_data,
	output logic    full,
	output logic    out_valid,
	input  logic    out_ready,
	output result_t out_data
);

	logic    main_valid_q;
	logic    skid_valid_q;
	result_t main_q;
	result_t skid_q;

	assign full      = skid_valid_q;
	assign out_valid = main_valid_q;
	assign out_data  = main_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (main_valid_q && out_ready) begin
			if (skid_valid_q) begin
				skid_valid_q <= 1'b0;
			end else begin
				main_valid_q <= push;
			end
		end else if (!main_valid_q) begin
			main_valid_q <= push;
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (main_valid_q && out_ready) begin
			main_q <= skid_valid_q ? skid_q : push_data;
		end else if (!main_valid_q) begin
			main_q <= push_data;
		end else if (push) begin
			skid_q <= push_data;
		end
	end

endmodule

// ----- rtl/riff_wave_stream_parser.sv -----
// RIFF/WAVE stream parser top level: one file byte per transfer in, header
// reports and 16-bit PCM words out. Each result is formed combinationally
// from the accepted byte and registered in the output buffer; throughput is
// one byte per cycle while the output buffer is not full. A two-entry output
// buffer absorbs output stall, and s_tready drops when both entries are in use.
// The asynchronous active-low reset returns the parser to expecting a RIFF header with all state cleared.
`include "assert_macros.svh"

module riff_wave_stream_parser import rwsp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [7:0]         s_tdata,   // data_byte[7:0]
	input  logic               s_tlast,   // stream_end
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [TDATA_W-1:0] m_tdata,   // status, fmt_code, channels, smp_rate,
	                                      // bytes_per_sec, frame_bytes, smp_bits,
	                                      // pcm_len, pcm_start, pcm_word, zero pad
	output logic [1:0]         m_tuser,   // kind
	output logic               m_tlast    // last
);

	logic    take;
	logic    res_valid;
	result_t res;
	logic    buf_full;
	result_t out_res;

	assign s_tready = !buf_full;
	assign take     = s_tvalid && s_tready;

	rwsp_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_take   (take),
		.in_byte   (s_tdata),
		.in_end    (s_tlast),
		.res_valid (res_valid),
		.res       (res)
	);

	rwsp_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_valid),
		.push_data (res),
		.full      (buf_full),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (out_res)
	);

	assign m_tdata = {6'd0, out_res.pcm_word, out_res.pcm_start, out_res.pcm_len,
		out_res.smp_bits, out_res.frame_bytes, out_res.bytes_per_sec,
		out_res.smp_rate, out_res.channels, out_res.fmt_code, out_res.status};
	assign m_tuser = out_res.kind;
	assign m_tlast = out_res.last;

	// A result only comes from an accepted byte.
	`ASSERT_SAME(a_res_needs_take, res_valid, take)
	// The skid stage is never loaded while the output register is empty.
	`ASSERT_SAME(a_skid_behind_main, buf_full, m_tvalid)
	// Draining a full buffer leaves the output register occupied.
	`ASSERT_NEXT(a_drain_keeps_main, buf_full && m_tready, m_tvalid && !buf_full)
	// A done result always closes the file.
	`ASSERT_SAME(a_done_is_last, m_tvalid && m_tuser == KIND_DONE, m_tlast)

endmodule
